// File: design/mbps_pkg.sv
package mbps_pkg;

    // Window depth default and fixed pattern storage
    localparam int MAX_PATTERN_DEF = 16;
    localparam int PATTERN_BYTES   = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_STRIDE   = 3'd4;

    // One window position as it moves down the chain
    typedef struct packed {
        logic [7:0] data;
        logic       aligned;
        logic       live;
    } cell_beat_t;

    // Pattern and care mask as seen by every cell
    typedef struct packed {
        logic [8*PATTERN_BYTES-1:0] pattern;
        logic [PATTERN_BYTES-1:0]   care;
    } cell_cfg_t;

endpackage

// File: design/mbps_phase.sv
module mbps_phase
    import mbps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       restart,
    input  logic [7:0] stride,
    output logic       aligned
);

    logic [7:0] phase_reg;
    logic [7:0] phase_next;
    logic [7:0] phase_cur;
    logic [8:0] phase_inc;
    logic [7:0] stride_eff;

    // Restart at region start, wrap at the stride
    always_comb
    begin
        phase_cur  = restart ? 8'd0 : phase_reg;
        aligned    = (phase_cur == 8'd0);
        stride_eff = (stride == 8'd0) ? 8'd1 : stride;
        phase_inc  = {1'b0, phase_cur} + 9'd1;
        if (phase_inc >= {1'b0, stride_eff})
        begin
            phase_next = 8'd0;
        end
        else
        begin
            phase_next = phase_inc[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// File: design/mbps_cell.sv
module mbps_cell
    import mbps_pkg::*;
#(
    parameter int POS   = 0,
    parameter int LEN_W = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             clear,
    input  cell_beat_t       beat_in,
    input  cell_cfg_t        cfg,
    input  logic [LEN_W-1:0] len,
    output cell_beat_t       beat_out,
    output cell_beat_t       beat_taken,
    output logic             ok
);

    cell_beat_t beat_reg;
    logic       active;
    logic [31:0] pat_idx;
    logic       care_eff;
    logic [7:0] pat_byte;

    // Drop the live mark at a region boundary
    always_comb
    begin
        beat_taken      = beat_in;
        beat_taken.live = beat_in.live & ~clear;
    end

    // Pick the pattern byte that lines up with this position
    always_comb
    begin
        active   = (32'(len) > POS);
        pat_idx  = 32'(len) - 32'd1 - 32'(POS);
        care_eff = 1'b0;
        pat_byte = 8'd0;
        if (active && (pat_idx < PATTERN_BYTES))
        begin
            care_eff = cfg.care[pat_idx[3:0]];
            pat_byte = cfg.pattern[{pat_idx[3:0], 3'b000} +: 8];
        end
        ok = !care_eff || (beat_taken.data == pat_byte);
    end

    // Advance one place per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= '0;
        end
        else if (advance)
        begin
            beat_reg <= beat_taken;
        end
    end

    assign beat_out = beat_reg;

endmodule

// File: design/masked_byte_pattern_search_unit.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_ready     data_byte, byte_address, region_first
// out      output     out_valid / out_ready   match_address
// cfg      input      cfg_write               cfg_index, cfg_data
//
// One byte is accepted per cycle while in_ready is high; its match shows next cycle.
// The window is a chain of MAX_PATTERN cells shifting once per accepted beat;
// the compare runs on the bytes entering the cells, so the match is registered.
// in_ready drops only while a match waits in the output register and out_ready is low.
// Reset clears the window, phase counter and configuration to their initial values.
module masked_byte_pattern_search_unit
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic [63:0]          byte_address,
    input  logic                 region_first,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [63:0]          match_address,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [63:0] pattern_low_reg;
    logic [63:0] pattern_high_reg;
    logic [15:0] care_mask_reg;
    logic [4:0]  pattern_length_reg;
    logic [7:0]  align_stride_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] match_address_reg;
    logic [63:0] match_address_next;

    logic             accept;
    logic             aligned_now;
    logic [LEN_W-1:0] len_eff;
    logic [IDX_W-1:0] last_pos;
    cell_cfg_t        cell_cfg;
    logic             hit;

    cell_beat_t beat_chain [MAX_PATTERN+1];
    cell_beat_t beat_taken [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_ok;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= 64'd0;
            pattern_high_reg   <= 64'd0;
            care_mask_reg      <= 16'd0;
            pattern_length_reg <= 5'd1;
            align_stride_reg   <= 8'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                REG_CARE_MASK:      care_mask_reg      <= cfg_data[15:0];
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[4:0];
                REG_ALIGN_STRIDE:   align_stride_reg   <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    // Clamp the pattern length into one to MAX_PATTERN
    always_comb
    begin
        if (pattern_length_reg == 5'd0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(pattern_length_reg) > MAX_PATTERN)
        begin
            len_eff = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len_eff = LEN_W'(pattern_length_reg);
        end
        last_pos = IDX_W'(32'(len_eff) - 32'd1);
    end

    assign cell_cfg.pattern = {pattern_high_reg, pattern_low_reg};
    assign cell_cfg.care    = care_mask_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Track the position within the alignment stride
    mbps_phase u_phase
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .restart (region_first),
        .stride  (align_stride_reg),
        .aligned (aligned_now)
    );

    // Feed the head of the chain
    always_comb
    begin
        beat_chain[0].data    = data_byte;
        beat_chain[0].aligned = aligned_now;
        beat_chain[0].live    = 1'b1;
    end

    // Window cells
    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        mbps_cell #(
            .POS   (k),
            .LEN_W (LEN_W)
        ) u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (accept),
            .clear      ((k == 0) ? 1'b0 : region_first),
            .beat_in    (beat_chain[k]),
            .cfg        (cell_cfg),
            .len        (len_eff),
            .beat_out   (beat_chain[k+1]),
            .beat_taken (beat_taken[k]),
            .ok         (cell_ok[k])
        );
    end

    // Test the window that this beat completes
    assign hit = (&cell_ok) && beat_taken[last_pos].live && beat_taken[last_pos].aligned;

    // Hold a match until taken, load on accept
    always_comb
    begin
        out_valid_next     = out_valid_reg;
        match_address_next = match_address_reg;
        if (accept)
        begin
            out_valid_next     = hit;
            match_address_next = byte_address - 64'(32'(len_eff) - 32'd1);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_address_reg <= match_address_next;
    end

    assign out_valid     = out_valid_reg;
    assign match_address = match_address_reg;

endmodule
